>>> rtl/assert_macros.svh
// assertion macros shared by the rtl of the frame parser
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> rtl/slcfp_pkg.sv
// shared types, constants and the crc-8 step of the frame parser
// no dependencies
package slcfp_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int CMD_DEPTH_DEF   = 2;
	localparam int RES_DEPTH_DEF   = 4;

	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int LEN_W     = 6;
	localparam int IDX_W     = 5;
	localparam int FILL_W    = 6;
	localparam int CMD_LEN_W = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;

	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BAD_LEN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CRC_ERR = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

	// work handed from the parser to the result builder
	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [BYTE_W-1:0]    id;
		logic [CMD_LEN_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] packet_id;
		logic [LEN_W-1:0]  payload_length;
		logic [IDX_W-1:0]  byte_index;
		logic [BYTE_W-1:0] data_byte;
		logic              last_item;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [FILL_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} ram_wr_t;

	// msb-first crc-8, no reflection, one byte
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/sync_length_crc8_frame_parser_core.sv
// Path: a byte's result passes the command queue, cmd_q, the result stage and the result queue.
// Throughput: one input byte per cycle; payload bytes stall while the back end still holds
// any command, since the payload store is shared, and every byte stalls on a full command queue.
// Replay: up to one payload result per cycle, set by the 4-entry result queue credits.
// Reset: arst_n clears parser, queues and sync registers; the payload store is not cleared.
`include "assert_macros.svh"

module sync_length_crc8_frame_parser_core #(
	parameter int MAX_PAYLOAD = slcfp_pkg::MAX_PAYLOAD_DEF,
	parameter int CMD_DEPTH   = slcfp_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH   = slcfp_pkg::RES_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [slcfp_pkg::BYTE_W-1:0]      in_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [slcfp_pkg::KIND_W-1:0]      kind,
	output logic [slcfp_pkg::BYTE_W-1:0]      packet_id,
	output logic [slcfp_pkg::LEN_W-1:0]       payload_length,
	output logic [slcfp_pkg::IDX_W-1:0]       byte_index,
	output logic [slcfp_pkg::BYTE_W-1:0]      data_byte,
	output logic                              last_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [slcfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slcfp_pkg::BYTE_W-1:0]      cfg_data
);

	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int RCW   = $clog2(RES_DEPTH + 1);
	localparam int CMD_W = $bits(slcfp_pkg::cmd_t);
	localparam int RES_W = $bits(slcfp_pkg::res_t);

	logic [slcfp_pkg::BYTE_W-1:0] sync_first_q;
	logic [slcfp_pkg::BYTE_W-1:0] sync_second_q;

	logic                 cmd_push;
	logic                 cmd_pop;
	logic                 cmd_full;
	logic                 cmd_empty;
	slcfp_pkg::cmd_t      cmd_in;
	slcfp_pkg::cmd_t      cmd_out;
	slcfp_pkg::ram_wr_t   ram_wr;
	logic                 replay_busy;

	logic                         ram_rd_en;
	logic [AW-1:0]                ram_rd_addr;
	logic [slcfp_pkg::BYTE_W-1:0] ram_rd_data;

	logic                 res_push;
	logic                 res_full;
	logic [RCW-1:0]       res_count;
	slcfp_pkg::res_t      res_in;
	slcfp_pkg::res_t      res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= '0;
			sync_second_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				slcfp_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				slcfp_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	slcfp_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_byte     (in_byte),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.cmd_full    (cmd_full),
		.replay_busy (replay_busy),
		.full        (full),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in),
		.ram_wr      (ram_wr)
	);

	slcfp_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_in),
		.pop     (cmd_pop),
		.rd_data (cmd_out),
		.full    (cmd_full),
		.empty   (cmd_empty),
		.count   ()
	);

	slcfp_ram #(
		.WIDTH (slcfp_pkg::BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr[AW-1:0]),
		.wdata (ram_wr.data),
		.re    (ram_rd_en),
		.raddr (ram_rd_addr),
		.rdata (ram_rd_data)
	);

	slcfp_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.RES_DEPTH   (RES_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd_out),
		.res_count   (res_count),
		.ram_rd_data (ram_rd_data),
		.cmd_pop     (cmd_pop),
		.replay_busy (replay_busy),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.res_push    (res_push),
		.res         (res_in)
	);

	slcfp_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.pop     (pop && !empty),
		.rd_data (res_out),
		.full    (res_full),
		.empty   (empty),
		.count   (res_count)
	);

	assign kind           = res_out.kind;
	assign packet_id      = res_out.packet_id;
	assign payload_length = res_out.payload_length;
	assign byte_index     = res_out.byte_index;
	assign data_byte      = res_out.data_byte;
	assign last_item      = res_out.last_item;

	`CHK_IMPL(a_cmd_no_overflow, cmd_push, !cmd_full, "command queue overflow")
	`CHK_IMPL(a_res_no_overflow, res_push, !res_full, "result queue overflow")
	`CHK_IMPL(a_store_not_in_use, ram_wr.en, !replay_busy, "payload write during replay")
	`CHK_NEXT(a_pop_starts_replay, cmd_pop, replay_busy, "back end idle after command pop")

endmodule

>>> rtl/slcfp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module slcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/slcfp_fifo.sv
// small register fifo used for the command queue and the result queue
// no dependencies
module slcfp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wr_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/slcfp_front.sv
// front end: sync hunt, header parse, payload store writes and crc check
// depends on slcfp_pkg
module slcfp_front #(
	parameter int MAX_PAYLOAD = slcfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [slcfp_pkg::BYTE_W-1:0]   in_byte,
	input  logic [slcfp_pkg::BYTE_W-1:0]   sync_first,
	input  logic [slcfp_pkg::BYTE_W-1:0]   sync_second,
	input  logic                           cmd_full,
	input  logic                           replay_busy,
	output logic                           full,
	output logic                           cmd_push,
	output slcfp_pkg::cmd_t                cmd,
	output slcfp_pkg::ram_wr_t             ram_wr
);

	localparam int LENQ_W = $clog2(MAX_PAYLOAD + 1);
	localparam int CLW    = slcfp_pkg::CMD_LEN_W;
	localparam logic [slcfp_pkg::BYTE_W-1:0] MAX_B = slcfp_pkg::BYTE_W'(MAX_PAYLOAD);
	localparam logic [CLW-1:0] MAX_C = CLW'(MAX_PAYLOAD);

	typedef enum logic [2:0] {
		PH_SYNC0,
		PH_SYNC1,
		PH_ID,
		PH_LEN,
		PH_DATA,
		PH_CRC,
		PH_DONE
	} phase_t;

	phase_t                              phase_q;
	logic [slcfp_pkg::BYTE_W-1:0]        id_q;
	logic [LENQ_W-1:0]                   len_q;
	logic [slcfp_pkg::FILL_W-1:0]        fill_q;
	logic [slcfp_pkg::BYTE_W-1:0]        crc_q;

	logic                                accept;
	logic                                bad_len;
	logic                                crc_ok;
	logic [slcfp_pkg::BYTE_W-1:0]        crc_next;
	logic [slcfp_pkg::FILL_W-1:0]        fill_inc;

	// hold off every byte on a full command queue, and payload writes while the back end holds any command
	assign full     = cmd_full || ((phase_q == PH_DATA) && replay_busy);
	assign accept   = push && !full;
	assign bad_len  = (in_byte == '0) || (in_byte > MAX_B);
	assign crc_ok   = (in_byte == crc_q);
	assign crc_next = slcfp_pkg::crc8_update(crc_q, in_byte);
	assign fill_inc = fill_q + 1'b1;

	always_comb begin
		cmd_push    = 1'b0;
		cmd.kind    = slcfp_pkg::KIND_DROPPED;
		cmd.id      = id_q;
		cmd.len     = '0;
		ram_wr.en   = accept && (phase_q == PH_DATA) && (CLW'(fill_q) < MAX_C);
		ram_wr.addr = fill_q;
		ram_wr.data = in_byte;
		case (phase_q)
			PH_LEN: begin
				cmd_push = accept && bad_len;
				cmd.kind = slcfp_pkg::KIND_BAD_LEN;
			end
			PH_CRC: begin
				cmd_push = accept;
				cmd.kind = crc_ok ? slcfp_pkg::KIND_PAYLOAD : slcfp_pkg::KIND_CRC_ERR;
				cmd.len  = crc_ok ? CLW'(len_q) : '0;
			end
			PH_DONE: begin
				cmd_push = accept;
				cmd.kind = slcfp_pkg::KIND_DROPPED;
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC0;
			id_q    <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			crc_q   <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_SYNC0: begin
					if (in_byte == sync_first) begin
						phase_q <= PH_SYNC1;
					end
				end
				PH_SYNC1: begin
					phase_q <= (in_byte == sync_second) ? PH_ID : PH_SYNC0;
				end
				PH_ID: begin
					id_q    <= in_byte;
					crc_q   <= slcfp_pkg::crc8_update('0, in_byte);
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					if (bad_len) begin
						phase_q <= PH_SYNC0;
						id_q    <= '0;
						len_q   <= '0;
						fill_q  <= '0;
						crc_q   <= '0;
					end else begin
						len_q   <= in_byte[LENQ_W-1:0];
						fill_q  <= '0;
						crc_q   <= crc_next;
						phase_q <= PH_DATA;
					end
				end
				PH_DATA: begin
					fill_q <= fill_inc;
					crc_q  <= crc_next;
					if (CLW'(fill_inc) >= CLW'(len_q)) begin
						phase_q <= PH_CRC;
					end
				end
				PH_CRC: begin
					if (crc_ok) begin
						phase_q <= PH_DONE;
					end else begin
						phase_q <= PH_SYNC0;
						id_q    <= '0;
						len_q   <= '0;
						fill_q  <= '0;
						crc_q   <= '0;
					end
				end
				default: begin
					// done, or a code that is never reached: back to the hunt
					phase_q <= PH_SYNC0;
					id_q    <= '0;
					len_q   <= '0;
					fill_q  <= '0;
					crc_q   <= '0;
				end
			endcase
		end
	end

endmodule

>>> rtl/slcfp_back.sv
// back end: turns queued commands into results, replaying payload from the store
// depends on slcfp_pkg
module slcfp_back #(
	parameter int MAX_PAYLOAD = slcfp_pkg::MAX_PAYLOAD_DEF,
	parameter int RES_DEPTH   = slcfp_pkg::RES_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_empty,
	input  slcfp_pkg::cmd_t                        cmd,
	input  logic [$clog2(RES_DEPTH+1)-1:0]         res_count,
	input  logic [slcfp_pkg::BYTE_W-1:0]           ram_rd_data,
	output logic                                   cmd_pop,
	output logic                                   replay_busy,
	output logic                                   ram_rd_en,
	output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] ram_rd_addr,
	output logic                                   res_push,
	output slcfp_pkg::res_t                        res
);

	localparam int AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CW  = $clog2(RES_DEPTH + 1);
	localparam int CLW = slcfp_pkg::CMD_LEN_W;
	localparam logic [CW:0] DEPTH_C = (CW + 1)'(RES_DEPTH);

	logic                 busy_q;
	slcfp_pkg::cmd_t      cmd_q;
	logic [CLW-1:0]       idx_q;

	logic                 valid_s1;
	slcfp_pkg::res_t      res_s1;

	logic                 is_pay;
	logic                 last_now;
	logic [CW:0]          used;
	logic                 issue;

	assign is_pay   = (cmd_q.kind == slcfp_pkg::KIND_PAYLOAD);
	assign last_now = !is_pay || ((idx_q + 1'b1) == cmd_q.len);
	// results in the queue plus the one in flight must leave a free slot
	assign used     = {1'b0, res_count} + {{CW{1'b0}}, valid_s1};
	assign issue    = busy_q && (used < DEPTH_C);

	assign cmd_pop     = !busy_q && !cmd_empty;
	assign replay_busy = busy_q || !cmd_empty;
	assign ram_rd_en   = issue && is_pay;
	assign ram_rd_addr = idx_q[AW-1:0];

	always_comb begin
		res          = res_s1;
		res.data_byte = (res_s1.kind == slcfp_pkg::KIND_PAYLOAD) ? ram_rd_data : '0;
	end
	assign res_push = valid_s1;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (issue) begin
			res_s1.kind           <= cmd_q.kind;
			res_s1.packet_id      <= cmd_q.id;
			res_s1.payload_length <= is_pay ? cmd_q.len[slcfp_pkg::LEN_W-1:0] : '0;
			res_s1.byte_index     <= is_pay ? idx_q[slcfp_pkg::IDX_W-1:0] : '0;
			res_s1.data_byte      <= '0;
			res_s1.last_item      <= last_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (cmd_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
				if (last_now) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule
